// ===== rtl/bfar_pkg.sv =====
// ----------------------------------------------------------------------------
// bfar_pkg: shared definitions of the box filter audio resampler
// Widths, fixed-point constants, register indexes and sequencer states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bfar_pkg;

	// fixed point: time in units of 2^-FRAC_BITS input samples
	localparam int FRAC_BITS       = 16;
	localparam int DEF_MAX_OUTPUTS = 8;

	localparam int SAMPLE_W   = 16;
	localparam int STEP_W     = 24;
	localparam int RECIP_W    = 20;
	localparam int MASK_W     = 5;
	localparam int GAIN_W     = 8;
	localparam int BYTE_W     = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = STEP_W;

	localparam int REM_W    = FRAC_BITS + 1;
	localparam int ACC_W    = SAMPLE_W + STEP_W + 1;
	localparam int MAG_W    = ACC_W - 1;
	localparam int HALF_W   = MAG_W / 2;
	localparam int MUL_A_W  = STEP_W;
	localparam int MUL_B_W  = RECIP_W;
	localparam int PROD_W   = MUL_A_W + MUL_B_W;
	localparam int PART_W   = HALF_W + RECIP_W;
	localparam int SCALE_SH = 2 * FRAC_BITS - HALF_W;
	localparam int Q_W      = PART_W + 1 - SCALE_SH;
	localparam int MASKED_W = SAMPLE_W + 2;
	localparam int ZRUN_W   = 5;

	localparam logic [STEP_W-1:0]  RESET_STEP  = STEP_W'(65536);
	localparam logic [RECIP_W-1:0] RESET_RECIP = RECIP_W'(65536);
	localparam logic [MASK_W-1:0]  KEEP_MAX    = MASK_W'(16);
	localparam logic [ZRUN_W-1:0]  ZERO_RUN_LIMIT = ZRUN_W'(20);
	localparam logic [ZRUN_W-1:0]  ZERO_RUN_MAX   = ZRUN_W'(31);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_STEP_RATIO,
		REG_RECIP_RATIO,
		REG_IN_8BIT,
		REG_IN_MONO,
		REG_OUT_MONO,
		REG_OUT_8BIT,
		REG_MASK_BITS,
		REG_OUT_SCALE
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_MUL_L,
		ST_MUL_R,
		ST_ADD_R,
		ST_SC_LL,
		ST_SC_LH,
		ST_SC_RL,
		ST_SC_RH,
		ST_SC_RX,
		ST_FIN_L,
		ST_FIN_R,
		ST_FIN_X,
		ST_PUSH
	} bfar_state_t;

endpackage

// ===== rtl/bfar_if.sv =====
// ----------------------------------------------------------------------------
// bfar_if: channel interfaces of the box filter audio resampler
// Input frame channel, result channel and register write channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bfar_frame_if import bfar_pkg::*; ;
	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] left_sample;
	logic [SAMPLE_W-1:0] right_sample;
	logic                stream_end;

	modport source (output valid, left_sample, right_sample, stream_end, input ready);
	modport sink (input valid, left_sample, right_sample, stream_end, output ready);
endinterface

interface bfar_result_if import bfar_pkg::*; ;
	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] left_word;
	logic [SAMPLE_W-1:0] right_word;
	logic                run_last;

	modport source (output valid, left_word, right_word, run_last, input ready);
	modport sink (input valid, left_word, right_word, run_last, output ready);
endinterface

interface bfar_cfg_if import bfar_pkg::*; ;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/box_filter_audio_resampler_unit.sv =====
// ----------------------------------------------------------------------------
// box_filter_audio_resampler_unit: area-averaging sample rate converter
// Each frame is spread over output intervals by overlap, each closed interval
// is scaled by the reciprocal ratio and formatted as 16-bit or byte output.
// An input frame is worked through each interval it closes in turn, plus any
// stalls of the result channel; frame ready is high only when idle. A result
// is pushed after the check, multiply, add, scale and format states.
// All work passes through one shared 24x20 multiplier under the sequencer.
// Reset: registers to defaults, residual 65536, accumulators zero,
// zero-run count 20, result register empty; no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module box_filter_audio_resampler_unit import bfar_pkg::*; #(
	parameter int MAX_OUTPUTS_PER_INPUT = DEF_MAX_OUTPUTS
) (
	input  logic                clk,
	input  logic                arst_n,
	bfar_frame_if.sink          frame,
	bfar_result_if.source       result,
	bfar_cfg_if.sink            cfg
);

	localparam int CNT_W = $clog2(MAX_OUTPUTS_PER_INPUT + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_OUTPUTS_PER_INPUT);
	localparam logic [STEP_W-1:0] MIN_STEP =
		STEP_W'(((1 << FRAC_BITS) + MAX_OUTPUTS_PER_INPUT - 1) / MAX_OUTPUTS_PER_INPUT);
	localparam logic [REM_W-1:0] UNIT_TIME = REM_W'(1 << FRAC_BITS);
	localparam logic [Q_W-1:0] SAT_NEG = Q_W'(32768);
	localparam logic [Q_W-1:0] SAT_POS = Q_W'(32767);

	function automatic logic signed [SAMPLE_W-1:0] decode_sample(
		input logic [SAMPLE_W-1:0] raw, input logic is_byte);
		logic [SAMPLE_W-1:0] v;
		// byte: (b << 8) - 32768 is the byte with its top bit flipped
		v = is_byte ? {~raw[BYTE_W-1], raw[BYTE_W-2:0], {BYTE_W{1'b0}}} : raw;
		return $signed(v);
	endfunction

	function automatic logic [SAMPLE_W-1:0] abs_sample(input logic signed [SAMPLE_W-1:0] s);
		logic signed [SAMPLE_W-1:0] neg;
		neg = -s;
		return s[SAMPLE_W-1] ? neg : s;
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] scale_clamp(
		input logic neg, input logic [Q_W-1:0] q);
		logic [SAMPLE_W-1:0] qs;
		logic [SAMPLE_W-1:0] qn;
		qs = q[SAMPLE_W-1:0];
		qn = -qs;
		if (neg) begin
			return (q > SAT_NEG) ? $signed(SAT_NEG[SAMPLE_W-1:0]) : $signed(qn);
		end
		return (q > SAT_POS) ? $signed(SAT_POS[SAMPLE_W-1:0]) : $signed(qs);
	endfunction

	function automatic logic signed [MASKED_W-1:0] mask_value(
		input logic signed [SAMPLE_W-1:0] v, input logic [MASK_W-1:0] mb);
		logic [MASK_W-1:0] keep;
		logic [SAMPLE_W-1:0] low;
		keep = (mb > KEEP_MAX) ? KEEP_MAX : mb;
		low = {SAMPLE_W{1'b1}} << (KEEP_MAX - keep);
		return $signed({v[SAMPLE_W-1], v[SAMPLE_W-1], v & low});
	endfunction

	function automatic logic [BYTE_W-1:0] to_byte(input logic signed [MASKED_W-1:0] m);
		logic signed [MASKED_W-1:0] x;
		x = m + $signed(MASKED_W'(32768));
		if (x[MASKED_W-1]) begin
			return '0;
		end
		return x[SAMPLE_W] ? {BYTE_W{1'b1}} : x[SAMPLE_W-1:BYTE_W];
	endfunction

	// exact x / 255 for x up to 255 * 255
	function automatic logic [BYTE_W-1:0] div255(input logic [SAMPLE_W-1:0] x);
		logic [SAMPLE_W:0] y;
		y = {1'b0, x} + (SAMPLE_W+1)'(x[SAMPLE_W-1:BYTE_W]) + (SAMPLE_W+1)'(1);
		return y[SAMPLE_W-1:BYTE_W];
	endfunction

	bfar_state_t state_q, state_d;

	// configuration
	logic [STEP_W-1:0]  step_q;
	logic [RECIP_W-1:0] recip_q;
	logic               in8_q, inmono_q, outmono_q, out8_q;
	logic [MASK_W-1:0]  maskb_q;
	logic [GAIN_W-1:0]  gain_q;

	// interval state
	logic [STEP_W-1:0]        res_q;
	logic [REM_W-1:0]         rem_q;
	logic [CNT_W-1:0]         n_q;
	logic                     emit_q, last_q, end_q;
	logic signed [ACC_W-1:0]  acc_l_q, acc_r_q;
	logic [ZRUN_W-1:0]        zcnt_q;

	// datapath payload
	logic signed [SAMPLE_W-1:0] sl_q, sr_q;
	logic [STEP_W-1:0]          seg_q;
	logic [PROD_W-1:0]          prod_q;
	logic [RECIP_W-1:0]         tmp_q;
	logic signed [SAMPLE_W-1:0] sc_l_q, sc_r_q;
	logic [SAMPLE_W-1:0]        w16_q, lfin_q, rfin_q;
	logic [BYTE_W-1:0]          nb_q;
	logic                       zero_q;

	// result register
	logic                ovalid_q, olast_q;
	logic [SAMPLE_W-1:0] oleft_q, oright_q;

	logic [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0] mul_b;
	logic               frame_ready;

	logic [STEP_W-1:0]  step_used, rem_ext, seg_d;
	logic               can_emit, more_after;
	logic [REM_W-1:0]   rem_after;
	logic [CNT_W-1:0]   n_after;
	logic signed [ACC_W-1:0] acc_sel, acc_neg, prod_ext;
	logic [MAG_W-1:0]   mag;
	logic [PART_W:0]    q_sum;
	logic [Q_W-1:0]     q_val;
	logic signed [SAMPLE_W:0]   mix_sum, mix_adj;
	logic signed [SAMPLE_W-1:0] mix_v, v0, fin_src;
	logic                       z0, fin_zero, mixdown;
	logic signed [MASKED_W-1:0] masked;
	logic [BYTE_W-1:0]          nb_d, fin_byte;
	logic [ZRUN_W-1:0]          zcnt_next;
	logic                       mute, slot_free;
	logic [SAMPLE_W-1:0]        fin_word;

	assign step_used = (step_q < MIN_STEP) ? MIN_STEP : step_q;
	assign rem_ext   = STEP_W'(rem_q);
	assign can_emit  = (rem_ext >= res_q) && (n_q < CNT_MAX);
	// when the output bound is hit the leftover time is dropped
	assign seg_d     = can_emit ? res_q :
		((rem_ext >= res_q) ? res_q - STEP_W'(1) : rem_ext);
	assign rem_after  = rem_q - seg_q[REM_W-1:0];
	assign n_after    = n_q + CNT_W'(1);
	assign more_after = (STEP_W'(rem_after) >= step_used) && (n_after < CNT_MAX);

	assign prod_ext = $signed({1'b0, prod_q[ACC_W-2:0]});

	assign acc_sel = (state_q == ST_SC_LL || state_q == ST_SC_LH) ? acc_l_q : acc_r_q;
	assign acc_neg = -acc_sel;
	assign mag     = acc_sel[ACC_W-1] ? acc_neg[MAG_W-1:0] : acc_sel[MAG_W-1:0];

	// (hi * r << HALF_W + lo * r) >> 2F, with lo * r pre-shifted into tmp_q
	assign q_sum = {1'b0, prod_q[PART_W-1:0]} + (PART_W+1)'(tmp_q);
	assign q_val = q_sum[PART_W:SCALE_SH];

	// mono mixdown, (l + r) / 2 truncated toward zero
	assign mixdown = outmono_q && !inmono_q;
	assign mix_sum = (SAMPLE_W+1)'(sc_l_q) + (SAMPLE_W+1)'(sc_r_q);
	assign mix_adj = mix_sum + $signed({{SAMPLE_W{1'b0}}, mix_sum[SAMPLE_W] & mix_sum[0]});
	assign mix_v   = mix_adj[SAMPLE_W:1];
	assign v0      = mixdown ? mix_v : sc_l_q;
	assign z0      = mixdown ? (sc_r_q == '0) : (sc_l_q == '0);

	assign fin_src  = (state_q == ST_FIN_L) ? v0 : sc_r_q;
	assign fin_zero = (state_q == ST_FIN_L) ? z0 : (sc_r_q == '0);
	assign masked   = mask_value(fin_src, maskb_q);
	assign nb_d     = to_byte(masked);

	assign zcnt_next = zero_q ?
		((zcnt_q == ZERO_RUN_MAX) ? zcnt_q : zcnt_q + ZRUN_W'(1)) : '0;
	assign mute      = zero_q && (zcnt_next > ZERO_RUN_LIMIT);
	assign fin_byte  = mute ? '0 : ((gain_q != '0) ? div255(prod_q[SAMPLE_W-1:0]) : nb_q);
	assign fin_word  = out8_q ? {{(SAMPLE_W-BYTE_W){1'b0}}, fin_byte} : w16_q;

	assign slot_free = !ovalid_q || result.ready;

	assign frame.ready      = frame_ready;
	assign cfg.ready        = 1'b1;
	assign result.valid      = ovalid_q;
	assign result.left_word  = oleft_q;
	assign result.right_word = oright_q;
	assign result.run_last   = olast_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		frame_ready = 1'b0;
		mul_a       = '0;
		mul_b       = '0;
		case (state_q)
			ST_IDLE: begin
				frame_ready = 1'b1;
				if (frame.valid) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				state_d = ST_MUL_L;
			end
			ST_MUL_L: begin
				mul_a   = seg_q;
				mul_b   = MUL_B_W'(abs_sample(sl_q));
				state_d = ST_MUL_R;
			end
			ST_MUL_R: begin
				mul_a   = seg_q;
				mul_b   = MUL_B_W'(abs_sample(sr_q));
				state_d = ST_ADD_R;
			end
			ST_ADD_R: begin
				state_d = emit_q ? ST_SC_LL : ST_IDLE;
			end
			ST_SC_LL: begin
				mul_a   = MUL_A_W'(mag[HALF_W-1:0]);
				mul_b   = recip_q;
				state_d = ST_SC_LH;
			end
			ST_SC_LH: begin
				mul_a   = MUL_A_W'(mag[MAG_W-1:HALF_W]);
				mul_b   = recip_q;
				state_d = ST_SC_RL;
			end
			ST_SC_RL: begin
				mul_a   = MUL_A_W'(mag[HALF_W-1:0]);
				mul_b   = recip_q;
				state_d = ST_SC_RH;
			end
			ST_SC_RH: begin
				mul_a   = MUL_A_W'(mag[MAG_W-1:HALF_W]);
				mul_b   = recip_q;
				state_d = ST_SC_RX;
			end
			ST_SC_RX: begin
				state_d = ST_FIN_L;
			end
			ST_FIN_L: begin
				mul_a   = MUL_A_W'(nb_d);
				mul_b   = MUL_B_W'(gain_q);
				state_d = ST_FIN_R;
			end
			ST_FIN_R: begin
				mul_a   = MUL_A_W'(nb_d);
				mul_b   = MUL_B_W'(gain_q);
				state_d = ST_FIN_X;
			end
			ST_FIN_X: begin
				state_d = ST_PUSH;
			end
			ST_PUSH: begin
				if (slot_free) begin
					state_d = ST_CHECK;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// shared multiplier, product registered every cycle
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q    <= RESET_STEP;
			recip_q   <= RESET_RECIP;
			in8_q     <= 1'b0;
			inmono_q  <= 1'b0;
			outmono_q <= 1'b0;
			out8_q    <= 1'b0;
			maskb_q   <= KEEP_MAX;
			gain_q    <= '0;
		end else if (cfg.valid) begin
			case (cfg_reg_t'(cfg.index))
				REG_STEP_RATIO:  step_q    <= cfg.data[STEP_W-1:0];
				REG_RECIP_RATIO: recip_q   <= cfg.data[RECIP_W-1:0];
				REG_IN_8BIT:     in8_q     <= cfg.data[0];
				REG_IN_MONO:     inmono_q  <= cfg.data[0];
				REG_OUT_MONO:    outmono_q <= cfg.data[0];
				REG_OUT_8BIT:    out8_q    <= cfg.data[0];
				REG_MASK_BITS:   maskb_q   <= cfg.data[MASK_W-1:0];
				REG_OUT_SCALE:   gain_q    <= cfg.data[GAIN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// interval, accumulator and zero-run state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q   <= RESET_STEP;
			rem_q   <= UNIT_TIME;
			n_q     <= '0;
			emit_q  <= 1'b0;
			last_q  <= 1'b0;
			end_q   <= 1'b0;
			acc_l_q <= '0;
			acc_r_q <= '0;
			zcnt_q  <= ZERO_RUN_LIMIT;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (frame.valid) begin
						rem_q <= UNIT_TIME;
						n_q   <= '0;
						end_q <= frame.stream_end;
						if (res_q == '0) begin
							res_q <= step_used;
						end
					end
				end
				ST_CHECK: begin
					emit_q <= can_emit;
				end
				ST_MUL_R: begin
					acc_l_q <= sl_q[SAMPLE_W-1] ? acc_l_q - prod_ext : acc_l_q + prod_ext;
				end
				ST_ADD_R: begin
					if (emit_q) begin
						acc_r_q <= sr_q[SAMPLE_W-1] ? acc_r_q - prod_ext : acc_r_q + prod_ext;
						rem_q   <= rem_after;
						res_q   <= step_used;
						n_q     <= n_after;
						last_q  <= !more_after;
					end else if (end_q) begin
						// stream end drops the open interval
						res_q   <= step_used;
						acc_l_q <= '0;
						acc_r_q <= '0;
						zcnt_q  <= ZERO_RUN_LIMIT;
					end else begin
						acc_r_q <= sr_q[SAMPLE_W-1] ? acc_r_q - prod_ext : acc_r_q + prod_ext;
						res_q   <= res_q - seg_q;
					end
				end
				ST_SC_RX: begin
					acc_l_q <= '0;
					acc_r_q <= '0;
				end
				ST_FIN_R: begin
					if (out8_q) begin
						zcnt_q <= zcnt_next;
					end
				end
				ST_FIN_X: begin
					if (out8_q && !outmono_q) begin
						zcnt_q <= zcnt_next;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// datapath payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (frame.valid) begin
					sl_q <= decode_sample(frame.left_sample, in8_q);
					sr_q <= inmono_q ? decode_sample(frame.left_sample, in8_q) :
						decode_sample(frame.right_sample, in8_q);
				end
			end
			ST_CHECK: begin
				seg_q <= seg_d;
			end
			ST_SC_LH: begin
				tmp_q <= prod_q[PART_W-1:HALF_W];
			end
			ST_SC_RL: begin
				sc_l_q <= scale_clamp(acc_l_q[ACC_W-1], q_val);
			end
			ST_SC_RH: begin
				tmp_q <= prod_q[PART_W-1:HALF_W];
			end
			ST_SC_RX: begin
				sc_r_q <= scale_clamp(acc_r_q[ACC_W-1], q_val);
			end
			ST_FIN_L: begin
				w16_q  <= masked[SAMPLE_W-1:0];
				nb_q   <= nb_d;
				zero_q <= fin_zero;
			end
			ST_FIN_R: begin
				lfin_q <= fin_word;
				w16_q  <= masked[SAMPLE_W-1:0];
				nb_q   <= nb_d;
				zero_q <= fin_zero;
			end
			ST_FIN_X: begin
				rfin_q <= outmono_q ? '0 : fin_word;
			end
			default: begin
			end
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (state_q == ST_PUSH && slot_free) begin
			ovalid_q <= 1'b1;
		end else if (result.ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_PUSH && slot_free) begin
			oleft_q  <= lfin_q;
			oright_q <= rfin_q;
			olast_q  <= last_q;
		end
	end

	// the residual is never empty once an item is in flight
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> (res_q != '0))
		else $error("residual is zero during item processing");

	assert property (@(posedge clk) disable iff (!arst_n)
		(n_q <= CNT_MAX) && (rem_q <= UNIT_TIME))
		else $error("output count or remaining time out of range");

	// a waiting result is never overwritten
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PUSH && ovalid_q && !result.ready) |=>
		(state_q == ST_PUSH && $stable(oleft_q) && $stable(oright_q)))
		else $error("result register overwritten while stalled");

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for box_filter_audio_resampler_unit
// Drives PCM frames through random idle gaps and result stalls, predicts every
// resampled output word from a local area-averaging model and compares each
// transfer on the result channel against the oldest pending prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
	import bfar_pkg::*;

	localparam longint unsigned UNIT_TIME = 64'd1 << FRAC_BITS;
	localparam longint unsigned MIN_STEP =
		(UNIT_TIME + DEF_MAX_OUTPUTS - 1) / DEF_MAX_OUTPUTS;
	localparam int RANDOM_ITEMS  = 290;
	localparam int SETTLE_CYCLES = 32;
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int REPORT_MAX    = 10;

	typedef struct {
		logic [STEP_W-1:0]  step;
		logic [RECIP_W-1:0] recip;
		logic               in8;
		logic               in_mono;
		logic               out_mono;
		logic               out8;
		logic [MASK_W-1:0]  mask;
		logic [GAIN_W-1:0]  scale;
	} resampler_regs_t;

	typedef struct {
		logic [SAMPLE_W-1:0] left;
		logic [SAMPLE_W-1:0] right;
		logic                last;
	} out_word_t;

	logic clk;
	logic arst_n;

	bfar_frame_if  frame_ch ();
	bfar_result_if result_ch ();
	bfar_cfg_if    cfg_ch ();

	box_filter_audio_resampler_unit uut (
		.clk    (clk),
		.arst_n (arst_n),
		.frame  (frame_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	// model state
	resampler_regs_t regs;
	longint unsigned resid;
	longint          acc_l;
	longint          acc_r;
	int              zero_run;
	out_word_t       pending_out[$];

	int  errors;
	int  cycles;
	bit  tx_gaps_on;
	bit  rx_stall_on;
	int  hold_len;
	int  stall_left;
	int  rx_gap;

	always #2 clk = ~clk;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80)
			return $urandom_range(1, 3);
		if (r < 95)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic int decode_pcm(logic [SAMPLE_W-1:0] raw);
		if (regs.in8)
			return (int'(raw[7:0]) << 8) - 32768;
		return int'($signed(raw));
	endfunction

	// area sum times reciprocal, truncated toward zero, clamped to 16 bits
	function automatic int scale_sum(longint acc);
		longint unsigned mag;
		longint unsigned q;
		mag = (acc < 0) ? -acc : acc;
		q = (mag * 64'(regs.recip)) >> (2 * FRAC_BITS);
		if (acc < 0)
			return (q > 32768) ? -32768 : -int'(q);
		return (q > 32767) ? 32767 : int'(q);
	endfunction

	function automatic logic [SAMPLE_W-1:0] format_word(int v, int zsamp);
		int          keep;
		logic [31:0] msk;
		logic [31:0] bits;
		int          n;
		keep = (regs.mask > KEEP_MAX) ? 16 : int'(regs.mask);
		msk = (32'hffff0000 >> keep) | 32'hffff0000;
		bits = v & msk;
		n = $signed(bits);
		if (!regs.out8)
			return 16'(n);
		n = (n + 32768) / 256;
		if (n < 0)
			n = 0;
		else if (n > 255)
			n = 255;
		if (regs.scale != 0)
			n = (n * int'(regs.scale)) / 255;
		// mute after a long run of silent samples, shared by both channels
		if (zsamp == 0) begin
			if (zero_run < ZERO_RUN_MAX)
				zero_run++;
			if (zero_run > ZERO_RUN_LIMIT)
				n = 0;
		end else begin
			zero_run = 0;
		end
		return 16'(n);
	endfunction

	// spread one frame over the output intervals it overlaps
	function automatic void resample_frame(logic [SAMPLE_W-1:0] ls, logic [SAMPLE_W-1:0] rs,
			logic last_frame);
		int              sl;
		int              sr;
		int              n;
		int              lv;
		int              rv;
		longint unsigned rem;
		longint unsigned stp;
		out_word_t       o;
		sl = decode_pcm(ls);
		sr = regs.in_mono ? sl : decode_pcm(rs);
		rem = UNIT_TIME;
		stp = (regs.step < MIN_STEP) ? MIN_STEP : 64'(regs.step);
		n = 0;
		if (resid == 0)
			resid = stp;
		while (rem >= resid && n < DEF_MAX_OUTPUTS) begin
			acc_l += longint'(sl) * longint'(resid);
			acc_r += longint'(sr) * longint'(resid);
			lv = scale_sum(acc_l);
			rv = scale_sum(acc_r);
			if (regs.out_mono) begin
				if (regs.in_mono)
					o.left = format_word(lv, lv);
				else
					o.left = format_word((lv + rv) / 2, rv);
				o.right = '0;
			end else begin
				o.left = format_word(lv, lv);
				o.right = format_word(rv, rv);
			end
			o.last = 1'b0;
			acc_l = 0;
			acc_r = 0;
			pending_out.push_back(o);
			n++;
			rem -= resid;
			resid = stp;
		end
		if (n > 0)
			pending_out[pending_out.size() - 1].last = 1'b1;
		if (rem >= resid)
			rem = resid - 1;
		acc_l += longint'(sl) * longint'(rem);
		acc_r += longint'(sr) * longint'(rem);
		resid -= rem;
		if (last_frame) begin
			resid = stp;
			acc_l = 0;
			acc_r = 0;
			zero_run = ZERO_RUN_LIMIT;
		end
	endfunction

	function automatic resampler_regs_t cfg_of(int step, int recip, bit in8, bit in_mono,
			bit out_mono, bit out8, int mask, int scale);
		resampler_regs_t c;
		c.step = STEP_W'(step);
		c.recip = RECIP_W'(recip);
		c.in8 = in8;
		c.in_mono = in_mono;
		c.out_mono = out_mono;
		c.out8 = out8;
		c.mask = MASK_W'(mask);
		c.scale = GAIN_W'(scale);
		return c;
	endfunction

	task automatic flag_error(string msg);
		errors++;
		if (errors <= REPORT_MAX)
			$display("%0t: %s", $realtime, msg);
	endtask

	// receiver: random stalls, or one long hold-off when requested
	always @(posedge clk) begin
		if (hold_len != 0) begin
			stall_left = hold_len;
			hold_len = 0;
			rx_gap = 0;
		end
		if (stall_left != 0) begin
			result_ch.ready <= 1'b0;
			stall_left--;
		end else if (rx_gap != 0) begin
			result_ch.ready <= 1'b0;
			rx_gap--;
		end else begin
			result_ch.ready <= 1'b1;
			if (rx_stall_on && $urandom_range(0, 99) < 25)
				rx_gap = pick_gap();
		end
	end

	out_word_t want;

	always @(posedge clk) begin
		if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
			if (pending_out.size() == 0) begin
				flag_error($sformatf("unexpected result left %h right %h last %b",
					result_ch.left_word, result_ch.right_word, result_ch.run_last));
			end else begin
				want = pending_out.pop_front();
				if (result_ch.left_word !== want.left)
					flag_error($sformatf("left_word: expected %h got %h",
						want.left, result_ch.left_word));
				if (result_ch.right_word !== want.right)
					flag_error($sformatf("right_word: expected %h got %h",
						want.right, result_ch.right_word));
				if (result_ch.run_last !== want.last)
					flag_error($sformatf("run_last: expected %b got %b",
						want.last, result_ch.run_last));
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// wait until every predicted word has been seen and the unit is idle
	task automatic drain();
		while (pending_out.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		case (idx)
			REG_STEP_RATIO:  regs.step = val[STEP_W-1:0];
			REG_RECIP_RATIO: regs.recip = val[RECIP_W-1:0];
			REG_IN_8BIT:     regs.in8 = val[0];
			REG_IN_MONO:     regs.in_mono = val[0];
			REG_OUT_MONO:    regs.out_mono = val[0];
			REG_OUT_8BIT:    regs.out8 = val[0];
			REG_MASK_BITS:   regs.mask = val[MASK_W-1:0];
			REG_OUT_SCALE:   regs.scale = val[GAIN_W-1:0];
			default: ;
		endcase
	endtask

	task automatic load_config(resampler_regs_t c);
		drain();
		write_reg(REG_STEP_RATIO, CFG_DATA_W'(c.step));
		write_reg(REG_RECIP_RATIO, CFG_DATA_W'(c.recip));
		write_reg(REG_IN_8BIT, CFG_DATA_W'(c.in8));
		write_reg(REG_IN_MONO, CFG_DATA_W'(c.in_mono));
		write_reg(REG_OUT_MONO, CFG_DATA_W'(c.out_mono));
		write_reg(REG_OUT_8BIT, CFG_DATA_W'(c.out8));
		write_reg(REG_MASK_BITS, CFG_DATA_W'(c.mask));
		write_reg(REG_OUT_SCALE, CFG_DATA_W'(c.scale));
		cfg_ch.valid <= 1'b0;
	endtask

	// one frame transfer, preceded by an optional idle gap
	task automatic send_frame(logic [SAMPLE_W-1:0] ls, logic [SAMPLE_W-1:0] rs, logic e);
		int gap;
		if (tx_gaps_on && $urandom_range(0, 99) < 30) begin
			gap = pick_gap();
			frame_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		frame_ch.valid <= 1'b1;
		frame_ch.left_sample <= ls;
		frame_ch.right_sample <= rs;
		frame_ch.stream_end <= e;
		do @(posedge clk); while (frame_ch.ready !== 1'b1);
		resample_frame(ls, rs, e);
	endtask

	task automatic end_frames();
		frame_ch.valid <= 1'b0;
	endtask

	function automatic logic [SAMPLE_W-1:0] rand_sample(int silence_pct);
		if ($urandom_range(0, 99) < silence_pct)
			return regs.in8 ? {8'($urandom_range(0, 255)), 8'h80} : '0;
		return SAMPLE_W'($urandom_range(0, 65535));
	endfunction

	// unity step from reset: one word per frame, exact interval boundaries
	task automatic test_reset_defaults();
		send_frame(16'h7fff, 16'h8000, 1'b0);
		send_frame(16'h8000, 16'h7fff, 1'b0);
		send_frame(16'hffff, 16'h0001, 1'b0);
		send_frame(16'h0000, 16'h0000, 1'b1);
		end_frames();
	endtask

	// zero step raised to the minimum, reciprocal matched to it, wide mask
	task automatic test_small_step_clamp();
		load_config(cfg_of(0, 524288, 0, 0, 0, 0, 31, 0));
		send_frame(16'h7fff, 16'h8000, 1'b0);
		send_frame(16'h1234, 16'hedcb, 1'b0);
		send_frame(16'h8000, 16'h7fff, 1'b1);
		end_frames();
	endtask

	// largest step: nothing closes, stream end drops the partial interval
	task automatic test_stream_drop();
		load_config(cfg_of(24'hffffff, 20'hfffff, 0, 1, 0, 0, 16, 0));
		send_frame(16'h7fff, 16'h0000, 1'b0);
		send_frame(16'h8000, 16'hffff, 1'b0);
		send_frame(16'hffff, 16'hffff, 1'b1);
		end_frames();
	endtask

	// byte in and out, upper byte ignored, silence mutes and count saturates
	task automatic test_byte_zero_run();
		load_config(cfg_of(8192, 524288, 1, 1, 0, 1, 16, 255));
		send_frame(16'hff80, 16'h1234, 1'b0);
		send_frame(16'h0080, 16'hffff, 1'b0);
		send_frame(16'h5a80, 16'h0000, 1'b0);
		send_frame(16'h00ff, 16'h0000, 1'b0);
		send_frame(16'h0000, 16'hffff, 1'b1);
		end_frames();
	endtask

	// stereo mixed down to mono, mask of zero, scaled byte output
	task automatic test_mono_mix_mask();
		load_config(cfg_of(24'h18000, 43690, 0, 0, 1, 1, 0, 128));
		send_frame(16'h7fff, 16'h7fff, 1'b0);
		send_frame(16'h8000, 16'h8000, 1'b0);
		send_frame(16'h0000, 16'h0001, 1'b0);
		send_frame(16'h8000, 16'h7fff, 1'b1);
		end_frames();
	endtask

	task automatic test_zero_recip();
		load_config(cfg_of(32768, 0, 1, 0, 1, 0, 5, 1));
		send_frame(16'hff00, 16'h00ff, 1'b0);
		send_frame(16'h1234, 16'h5678, 1'b1);
		end_frames();
	endtask

	// receiver holds off while frames keep coming, so the input stalls
	task automatic test_input_stall();
		load_config(cfg_of(8192, 524288, 0, 0, 0, 0, 16, 0));
		tx_gaps_on = 1'b0;
		hold_len = 300;
		repeat (10) send_frame(rand_sample(0), rand_sample(0), 1'b0);
		end_frames();
		tx_gaps_on = 1'b1;
	endtask

	task automatic test_random_streams();
		int              sent;
		int              len;
		int              silence;
		int              r;
		longint unsigned s;
		resampler_regs_t c;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			r = $urandom_range(0, 99);
			if (r < 8)
				c.step = $urandom_range(0, MIN_STEP - 1);
			else if (r < 16)
				c.step = MIN_STEP;
			else if (r < 22)
				c.step = 65536;
			else if (r < 28)
				c.step = $urandom_range(24'h20000, 24'hffffff);
			else
				c.step = $urandom_range(MIN_STEP, 24'h28000);
			s = (c.step < MIN_STEP) ? MIN_STEP : 64'(c.step);
			r = $urandom_range(0, 99);
			if (r < 10)
				c.recip = $urandom_range(0, 20'hfffff);
			else if (r < 15)
				c.recip = '0;
			else if (r < 20)
				c.recip = 524288;
			else begin
				s = (64'd1 << (2 * FRAC_BITS)) / s;
				c.recip = (s > 524288) ? 524288 : s;
			end
			c.in8 = $urandom_range(0, 1);
			c.in_mono = $urandom_range(0, 1);
			c.out_mono = $urandom_range(0, 1);
			c.out8 = $urandom_range(0, 1);
			c.mask = ($urandom_range(0, 99) < 60) ? 16 : $urandom_range(0, 31);
			r = $urandom_range(0, 99);
			c.scale = (r < 40) ? 0 : (r < 50) ? 255 : $urandom_range(0, 255);
			load_config(c);
			// some phases run with no idling on either side
			tx_gaps_on = ($urandom_range(0, 3) != 0);
			rx_stall_on = ($urandom_range(0, 3) != 0);
			silence = ($urandom_range(0, 3) == 0) ? 70 : 0;
			len = $urandom_range(12, 36);
			repeat (len)
				send_frame(rand_sample(silence), rand_sample(silence),
					$urandom_range(0, 99) < 4);
			end_frames();
			sent += len;
		end
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		frame_ch.valid = 1'b0;
		frame_ch.left_sample = '0;
		frame_ch.right_sample = '0;
		frame_ch.stream_end = 1'b0;
		result_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_STEP_RATIO;
		cfg_ch.data = '0;
		errors = 0;
		cycles = 0;
		tx_gaps_on = 1'b1;
		rx_stall_on = 1'b1;
		hold_len = 0;
		stall_left = 0;
		rx_gap = 0;
		regs = cfg_of(RESET_STEP, RESET_RECIP, 0, 0, 0, 0, KEEP_MAX, 0);
		resid = RESET_STEP;
		acc_l = 0;
		acc_r = 0;
		zero_run = ZERO_RUN_LIMIT;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_small_step_clamp();
		test_stream_drop();
		test_byte_zero_run();
		test_mono_mix_mask();
		test_zero_recip();
		test_input_stall();
		test_random_streams();
		drain();

		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
